// ===== rtl/fam_pkg.sv =====
// Fuzzy ARTMAP classifier: shared types, state codes and result codes.
// No dependencies; used by fam_front, fam_back and the top level.
`timescale 1ns / 1ps

package fam_pkg;

   typedef struct packed {
      logic        func;
      logic [15:0] element_value;
      logic [3:0]  label;
      logic        last_element;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [3:0]  predicted_label;
      logic [4:0]  category;
      logic [15:0] match_value;
   } rsp_type;

   // one queued vector: mode and target label from its final element
   typedef struct packed {
      logic       func;
      logic [3:0] label;
   } cmd_type;

   typedef struct packed {
      logic [15:0] vigilance;
      logic [15:0] choice_bias;
      logic [15:0] tracking_step;
      logic [6:0]  vector_length;
      logic [4:0]  label_count;
   } cfg_type;

   localparam logic [2:0] CSR_VIGILANCE     = 3'd0;
   localparam logic [2:0] CSR_CHOICE_BIAS   = 3'd1;
   localparam logic [2:0] CSR_TRACKING_STEP = 3'd2;
   localparam logic [2:0] CSR_VECTOR_LENGTH = 3'd3;
   localparam logic [2:0] CSR_LABEL_COUNT   = 3'd4;

   localparam logic [2:0] STAT_CLASSIFIED   = 3'd0;
   localparam logic [2:0] STAT_UNCLASSIFIED = 3'd1;
   localparam logic [2:0] STAT_LEARNED      = 3'd2;
   localparam logic [2:0] STAT_COMMITTED    = 3'd3;
   localparam logic [2:0] STAT_FULL         = 3'd4;

   localparam logic FUNC_LEARN = 1'b1;

   localparam logic [15:0] Q16_ONE = 16'hFFFF;

   typedef enum logic [4:0] {
      ST_WIPE,
      ST_IDLE,
      ST_NORM,
      ST_SEARCH,
      ST_TRY,
      ST_SCAN,
      ST_NODE_SUM,
      ST_NODE_DIV,
      ST_COMPARE,
      ST_MATCH,
      ST_MATCH_DIV,
      ST_CHECK,
      ST_PREDICT,
      ST_NOT_FOUND,
      ST_COMMIT,
      ST_LEARN_MAP,
      ST_LEARN,
      ST_RESULT
   } state_type;

endpackage

// ===== rtl/fam_div.sv =====
// Restoring divider, one quotient bit per cycle.
// Depends on nothing; used by fam_back for choice and match ratios.
`timescale 1ns / 1ps

module fam_div #(
   parameter int DVD_W = 39,
   parameter int DIV_W = 24
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DVD_W-1:0] dividend,
   input  logic [DIV_W-1:0] divisor,
   output logic             done,
   output logic [DVD_W-1:0] quotient
);

   localparam int CNT_W = $clog2(DVD_W + 1);

   logic             run_ff, run_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [DVD_W-1:0] quo_ff, quo_in;
   logic [DIV_W:0]   rem_ff, rem_in;
   logic [DIV_W-1:0] dsr_ff, dsr_in;
   logic [DIV_W:0]   rem_sh;
   logic [DIV_W:0]   rem_sub;

   assign rem_sh  = {rem_ff[DIV_W-1:0], quo_ff[DVD_W-1]};
   assign rem_sub = rem_sh - {1'b0, dsr_ff};

   always_comb begin
      run_in  = run_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      if (start) begin
         run_in = 1'b1;
         cnt_in = CNT_W'(DVD_W);
         quo_in = dividend;
         rem_in = '0;
         dsr_in = divisor;
      end else if (run_ff) begin
         if (rem_sh >= {1'b0, dsr_ff}) begin
            rem_in = rem_sub;
            quo_in = {quo_ff[DVD_W-2:0], 1'b1};
         end else begin
            rem_in = rem_sh;
            quo_in = {quo_ff[DVD_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ===== rtl/fam_front.sv =====
// Front end: takes element requests, fills the input buffer, queues a vector.
// Depends on fam_pkg; feeds fam_back through a one-entry command queue.
`timescale 1ns / 1ps

module fam_front #(
   parameter int MAX_INPUTS = 64,
   localparam int IW = (MAX_INPUTS > 1) ? $clog2(MAX_INPUTS) : 1
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  fam_pkg::req_type       req,
   output logic                   busy,
   input  logic                   back_busy,
   output logic                   cmd_valid,
   output fam_pkg::cmd_type       cmd,
   input  logic                   cmd_pop,
   input  logic [IW-1:0]          rd_addr,
   output logic [15:0]            rd_data
);

   logic [15:0]      buf_mem [MAX_INPUTS];
   logic [15:0]      rd_data_ff;
   logic [IW-1:0]    load_idx_ff, load_idx_in;
   logic             q_v_ff, q_v_in;
   fam_pkg::cmd_type cmd_ff, cmd_in;
   logic             accept;

   // buffer must stay still while the back end walks it
   assign busy   = q_v_ff | back_busy;
   assign accept = start & ~busy;

   always_comb begin
      load_idx_in = load_idx_ff;
      q_v_in      = q_v_ff;
      cmd_in      = cmd_ff;
      if (cmd_pop) q_v_in = 1'b0;
      if (accept) begin
         if (req.last_element) begin
            load_idx_in = '0;
            q_v_in      = 1'b1;
            cmd_in.func  = req.func;
            cmd_in.label = req.label;
         end else if (load_idx_ff == IW'(MAX_INPUTS - 1)) begin
            load_idx_in = '0;
         end else begin
            load_idx_in = load_idx_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         load_idx_ff <= '0;
         q_v_ff      <= 1'b0;
      end else begin
         load_idx_ff <= load_idx_in;
         q_v_ff      <= q_v_in;
      end
      cmd_ff <= cmd_in;
   end

   always_ff @(posedge clock) begin
      if (accept) buf_mem[load_idx_ff] <= req.element_value;
      rd_data_ff <= buf_mem[rd_addr];
   end

   assign cmd_valid = q_v_ff;
   assign cmd       = cmd_ff;
   assign rd_data   = rd_data_ff;

endmodule

// ===== rtl/fam_back.sv =====
// Back end: category search, vigilance, match tracking and learning.
// Depends on fam_pkg and fam_div; reads the input buffer held in fam_front.
`timescale 1ns / 1ps

module fam_back #(
   parameter int MAX_INPUTS = 64,
   parameter int MAX_NODES  = 32,
   parameter int MAX_LABELS = 16,
   localparam int IW = (MAX_INPUTS > 1) ? $clog2(MAX_INPUTS) : 1
) (
   input  logic             clock,
   input  logic             reset,
   input  fam_pkg::cfg_type cfg,
   input  logic             cmd_valid,
   input  fam_pkg::cmd_type cmd,
   output logic             cmd_pop,
   output logic             active,
   output logic [IW-1:0]    rd_addr,
   input  logic [15:0]      rd_data,
   output logic             rsp_valid,
   output fam_pkg::rsp_type rsp
);

   localparam int LW    = $clog2(MAX_INPUTS + 1);
   localparam int NW    = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
   localparam int CW    = $clog2(MAX_NODES + 1);
   localparam int WD    = MAX_NODES * MAX_INPUTS;
   localparam int WAW   = (WD > 1) ? $clog2(WD) : 1;
   localparam int NRM_W = 16 + LW;
   localparam int DIV_W = NRM_W + 1;
   localparam int DVD_W = NRM_W + 16;
   localparam int PW    = (MAX_LABELS > 1) ? $clog2(MAX_LABELS) : 1;
   localparam int NLW   = $clog2(MAX_LABELS + 1);

   fam_pkg::state_type state_ff, state_in;

   logic                 func_ff, func_in;
   logic [3:0]           label_ff, label_in;
   logic [16:0]          rho_ff, rho_in;
   logic [NRM_W-1:0]     norm_i_ff, norm_i_in;
   logic [NRM_W-1:0]     sum_i_ff, sum_i_in;
   logic [NRM_W-1:0]     sum_w_ff, sum_w_in;
   logic [LW-1:0]        cnt_ff, cnt_in;
   logic                 pipe_v_ff, pipe_v_in;
   logic [IW-1:0]        pipe_idx_ff, pipe_idx_in;
   logic [CW-1:0]        j_ff, j_in;
   logic [MAX_NODES-1:0] flags_ff, flags_in;
   logic [1:0]           tries_ff, tries_in;
   logic                 best_v_ff, best_v_in;
   logic [NW-1:0]        best_ff, best_in;
   logic [DVD_W-1:0]     best_t_ff, best_t_in;
   logic [NRM_W-1:0]     best_int_ff, best_int_in;
   logic [DVD_W-1:0]     t_ff, t_in;
   logic [15:0]          m_ff, m_in;
   logic [CW-1:0]        count_ff, count_in;
   logic [NW-1:0]        node_ff, node_in;
   logic [2:0]           status_ff, status_in;
   logic [3:0]           plabel_ff, plabel_in;
   logic [NW-1:0]        cat_ff, cat_in;
   logic [WAW-1:0]       wipe_ff, wipe_in;

   logic [15:0]           w_mem [WD];
   logic [15:0]           w_rd_ff;
   logic [MAX_LABELS-1:0] map_ff [MAX_NODES];

   logic [LW-1:0]       len;
   logic [NLW-1:0]      nlab;
   logic [15:0]         step;
   logic                issue;
   logic                sum_done;
   logic [NW-1:0]       cur_node;
   logic [WAW-1:0]      w_raddr;
   logic                w_we;
   logic [WAW-1:0]      w_waddr;
   logic [15:0]         w_wdata;
   logic [15:0]         min_iw;
   logic [DIV_W-1:0]    choice_den;
   logic                div_start;
   logic [DVD_W-1:0]    div_dvd;
   logic [DIV_W-1:0]    div_dsr;
   logic                div_done;
   logic [DVD_W-1:0]    div_quo;
   logic                p_found;
   logic [PW-1:0]       p_idx;
   logic [MAX_LABELS-1:0] map_row;
   logic                map_we;
   logic [MAX_LABELS-1:0] map_wdata;

   // register clamps
   always_comb begin
      if (cfg.vector_length == 7'd0) begin
         len = LW'(1);
      end else if ({2'b00, cfg.vector_length} > 9'(MAX_INPUTS)) begin
         len = LW'(MAX_INPUTS);
      end else begin
         len = LW'(cfg.vector_length);
      end
      if (cfg.label_count == 5'd0) begin
         nlab = NLW'(1);
      end else if ({2'b00, cfg.label_count} > 7'(MAX_LABELS)) begin
         nlab = NLW'(MAX_LABELS);
      end else begin
         nlab = NLW'(cfg.label_count);
      end
      step = (cfg.tracking_step == 16'd0) ? 16'd1 : cfg.tracking_step;
   end

   // streaming walk over the vector: read issued at cnt, data registered and used in the cycle after
   assign issue    = (state_ff == fam_pkg::ST_NORM || state_ff == fam_pkg::ST_NODE_SUM ||
                      state_ff == fam_pkg::ST_LEARN) && (cnt_ff < len);
   assign sum_done = (cnt_ff == len) && !pipe_v_ff;
   assign rd_addr  = cnt_ff[IW-1:0];
   assign cur_node = (state_ff == fam_pkg::ST_LEARN) ? node_ff : j_ff[NW-1:0];
   assign w_raddr  = WAW'(cur_node) * WAW'(MAX_INPUTS) + WAW'(cnt_ff[IW-1:0]);
   assign min_iw   = (rd_data < w_rd_ff) ? rd_data : w_rd_ff;
   assign choice_den = DIV_W'(cfg.choice_bias) + DIV_W'(sum_w_ff);

   always_comb begin
      w_we    = 1'b0;
      w_waddr = WAW'(node_ff) * WAW'(MAX_INPUTS) + WAW'(pipe_idx_ff);
      w_wdata = min_iw;
      if (state_ff == fam_pkg::ST_WIPE) begin
         w_we    = 1'b1;
         w_waddr = wipe_ff;
         w_wdata = fam_pkg::Q16_ONE;
      end else if (state_ff == fam_pkg::ST_LEARN && pipe_v_ff) begin
         w_we = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (w_we) w_mem[w_waddr] <= w_wdata;
      w_rd_ff <= w_mem[w_raddr];
   end

   // first label in use whose map bit is set
   assign map_row = map_ff[best_ff];
   always_comb begin
      p_found = 1'b0;
      p_idx   = '0;
      for (int k = 0; k < MAX_LABELS; k++) begin
         if (!p_found && map_row[k] && (k < int'(nlab))) begin
            p_found = 1'b1;
            p_idx   = PW'(k);
         end
      end
   end

   assign map_we = (state_ff == fam_pkg::ST_LEARN_MAP);
   always_comb begin
      map_wdata = map_ff[node_ff];
      for (int k = 0; k < MAX_LABELS; k++) begin
         if ((k < int'(nlab)) && (k != int'(label_ff))) map_wdata[k] = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int n = 0; n < MAX_NODES; n++) map_ff[n] <= '1;
      end else if (map_we) begin
         map_ff[node_ff] <= map_wdata;
      end
   end

   fam_div #(
      .DVD_W(DVD_W),
      .DIV_W(DIV_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dvd),
      .divisor  (div_dsr),
      .done     (div_done),
      .quotient (div_quo)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         fam_pkg::ST_WIPE:
            if (wipe_ff == WAW'(WD - 1)) state_in = fam_pkg::ST_IDLE;
         fam_pkg::ST_IDLE:
            if (cmd_valid) state_in = fam_pkg::ST_NORM;
         fam_pkg::ST_NORM:
            if (sum_done) state_in = fam_pkg::ST_SEARCH;
         fam_pkg::ST_SEARCH:
            state_in = fam_pkg::ST_TRY;
         fam_pkg::ST_TRY:
            if (func_ff != fam_pkg::FUNC_LEARN && tries_ff == 2'd2) begin
               state_in = fam_pkg::ST_RESULT;
            end else begin
               state_in = fam_pkg::ST_SCAN;
            end
         fam_pkg::ST_SCAN:
            if (j_ff >= count_ff) begin
               state_in = best_v_ff ? fam_pkg::ST_MATCH : fam_pkg::ST_NOT_FOUND;
            end else if (!flags_ff[j_ff[NW-1:0]]) begin
               state_in = fam_pkg::ST_NODE_SUM;
            end
         fam_pkg::ST_NODE_SUM:
            if (sum_done) begin
               state_in = (choice_den == '0) ? fam_pkg::ST_COMPARE : fam_pkg::ST_NODE_DIV;
            end
         fam_pkg::ST_NODE_DIV:
            if (div_done) state_in = fam_pkg::ST_COMPARE;
         fam_pkg::ST_COMPARE:
            state_in = fam_pkg::ST_SCAN;
         fam_pkg::ST_MATCH:
            state_in = (norm_i_ff == '0) ? fam_pkg::ST_CHECK : fam_pkg::ST_MATCH_DIV;
         fam_pkg::ST_MATCH_DIV:
            if (div_done) state_in = fam_pkg::ST_CHECK;
         fam_pkg::ST_CHECK:
            state_in = ({1'b0, m_ff} < rho_ff) ? fam_pkg::ST_TRY : fam_pkg::ST_PREDICT;
         fam_pkg::ST_PREDICT:
            if (func_ff != fam_pkg::FUNC_LEARN) begin
               state_in = fam_pkg::ST_RESULT;
            end else if (p_found && (8'(p_idx) == 8'(label_ff))) begin
               state_in = fam_pkg::ST_LEARN_MAP;
            end else if (p_found) begin
               state_in = fam_pkg::ST_SEARCH;
            end else begin
               state_in = fam_pkg::ST_COMMIT;
            end
         fam_pkg::ST_NOT_FOUND:
            state_in = (func_ff == fam_pkg::FUNC_LEARN) ? fam_pkg::ST_COMMIT
                                                         : fam_pkg::ST_RESULT;
         fam_pkg::ST_COMMIT:
            state_in = (count_ff < CW'(MAX_NODES)) ? fam_pkg::ST_LEARN_MAP
                                                    : fam_pkg::ST_RESULT;
         fam_pkg::ST_LEARN_MAP:
            state_in = fam_pkg::ST_LEARN;
         fam_pkg::ST_LEARN:
            if (sum_done) state_in = fam_pkg::ST_RESULT;
         fam_pkg::ST_RESULT:
            state_in = fam_pkg::ST_IDLE;
         default:
            state_in = fam_pkg::ST_IDLE;
      endcase
   end

   // datapath updates
   always_comb begin
      func_in     = func_ff;
      label_in    = label_ff;
      rho_in      = rho_ff;
      norm_i_in   = norm_i_ff;
      sum_i_in    = sum_i_ff;
      sum_w_in    = sum_w_ff;
      cnt_in      = cnt_ff;
      pipe_v_in   = issue;
      pipe_idx_in = cnt_ff[IW-1:0];
      j_in        = j_ff;
      flags_in    = flags_ff;
      tries_in    = tries_ff;
      best_v_in   = best_v_ff;
      best_in     = best_ff;
      best_t_in   = best_t_ff;
      best_int_in = best_int_ff;
      t_in        = t_ff;
      m_in        = m_ff;
      count_in    = count_ff;
      node_in     = node_ff;
      status_in   = status_ff;
      plabel_in   = plabel_ff;
      cat_in      = cat_ff;
      wipe_in     = wipe_ff;
      cmd_pop     = 1'b0;
      div_start   = 1'b0;
      div_dvd     = {sum_i_ff, 16'd0};
      div_dsr     = choice_den;

      if (issue) cnt_in = cnt_ff + 1'b1;

      case (state_ff)
         fam_pkg::ST_WIPE:
            wipe_in = wipe_ff + 1'b1;
         fam_pkg::ST_IDLE:
            if (cmd_valid) begin
               cmd_pop   = 1'b1;
               func_in   = cmd.func;
               label_in  = cmd.label;
               rho_in    = {1'b0, cfg.vigilance};
               norm_i_in = '0;
               cnt_in    = '0;
               m_in      = '0;
               status_in = fam_pkg::STAT_UNCLASSIFIED;
               plabel_in = (cmd.func == fam_pkg::FUNC_LEARN) ? cmd.label : 4'd0;
               cat_in    = '0;
            end
         fam_pkg::ST_NORM:
            if (pipe_v_ff) norm_i_in = norm_i_ff + NRM_W'(rd_data);
         fam_pkg::ST_SEARCH: begin
            flags_in = '0;
            tries_in = '0;
         end
         fam_pkg::ST_TRY:
            if (func_ff != fam_pkg::FUNC_LEARN && tries_ff == 2'd2) begin
               m_in      = '0;
               status_in = fam_pkg::STAT_UNCLASSIFIED;
               plabel_in = '0;
               cat_in    = '0;
            end else begin
               tries_in  = tries_ff + 1'b1;
               j_in      = '0;
               best_v_in = 1'b0;
            end
         fam_pkg::ST_SCAN: begin
            cnt_in   = '0;
            sum_i_in = '0;
            sum_w_in = '0;
            if (j_ff < count_ff && flags_ff[j_ff[NW-1:0]]) j_in = j_ff + 1'b1;
         end
         fam_pkg::ST_NODE_SUM:
            if (pipe_v_ff) begin
               sum_i_in = sum_i_ff + NRM_W'(min_iw);
               sum_w_in = sum_w_ff + NRM_W'(w_rd_ff);
            end else if (sum_done) begin
               t_in = '0;
               if (choice_den != '0) div_start = 1'b1;
            end
         fam_pkg::ST_NODE_DIV:
            if (div_done) t_in = div_quo;
         fam_pkg::ST_COMPARE: begin
            if (!best_v_ff || t_ff > best_t_ff) begin
               best_v_in   = 1'b1;
               best_in     = j_ff[NW-1:0];
               best_t_in   = t_ff;
               best_int_in = sum_i_ff;
            end
            j_in = j_ff + 1'b1;
         end
         fam_pkg::ST_MATCH: begin
            // |I^z| * 65535 as a shift and a subtract
            div_dvd = {best_int_ff, 16'd0} - DVD_W'(best_int_ff);
            div_dsr = DIV_W'(norm_i_ff);
            if (norm_i_ff == '0) begin
               m_in = fam_pkg::Q16_ONE;
            end else begin
               div_start = 1'b1;
            end
         end
         fam_pkg::ST_MATCH_DIV:
            if (div_done) m_in = div_quo[15:0];
         fam_pkg::ST_CHECK:
            if ({1'b0, m_ff} < rho_ff) flags_in[best_ff] = 1'b1;
         fam_pkg::ST_PREDICT:
            if (func_ff != fam_pkg::FUNC_LEARN) begin
               cat_in = best_ff;
               if (p_found) begin
                  status_in = fam_pkg::STAT_CLASSIFIED;
                  plabel_in = 4'(p_idx);
               end
            end else if (p_found && (8'(p_idx) == 8'(label_ff))) begin
               node_in   = best_ff;
               cat_in    = best_ff;
               status_in = fam_pkg::STAT_LEARNED;
            end else if (p_found) begin
               rho_in = {1'b0, m_ff} + {1'b0, step};
            end
         fam_pkg::ST_NOT_FOUND:
            if (func_ff != fam_pkg::FUNC_LEARN) begin
               status_in = fam_pkg::STAT_UNCLASSIFIED;
               plabel_in = '0;
               cat_in    = '0;
            end
         fam_pkg::ST_COMMIT:
            if (count_ff < CW'(MAX_NODES)) begin
               node_in   = count_ff[NW-1:0];
               cat_in    = count_ff[NW-1:0];
               count_in  = count_ff + 1'b1;
               status_in = fam_pkg::STAT_COMMITTED;
            end else begin
               status_in = fam_pkg::STAT_FULL;
               cat_in    = '0;
            end
         fam_pkg::ST_LEARN_MAP:
            cnt_in = '0;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= fam_pkg::ST_WIPE;
         wipe_ff   <= '0;
         count_ff  <= '0;
         pipe_v_ff <= 1'b0;
         flags_ff  <= '0;
         rho_ff    <= 17'd58982;
      end else begin
         state_ff  <= state_in;
         wipe_ff   <= wipe_in;
         count_ff  <= count_in;
         pipe_v_ff <= pipe_v_in;
         flags_ff  <= flags_in;
         rho_ff    <= rho_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff     <= func_in;
      label_ff    <= label_in;
      norm_i_ff   <= norm_i_in;
      sum_i_ff    <= sum_i_in;
      sum_w_ff    <= sum_w_in;
      cnt_ff      <= cnt_in;
      pipe_idx_ff <= pipe_idx_in;
      j_ff        <= j_in;
      tries_ff    <= tries_in;
      best_v_ff   <= best_v_in;
      best_ff     <= best_in;
      best_t_ff   <= best_t_in;
      best_int_ff <= best_int_in;
      t_ff        <= t_in;
      m_ff        <= m_in;
      node_ff     <= node_in;
      status_ff   <= status_in;
      plabel_ff   <= plabel_in;
      cat_ff      <= cat_in;
   end

   assign active    = (state_ff != fam_pkg::ST_IDLE);
   assign rsp_valid = (state_ff == fam_pkg::ST_RESULT);
   assign rsp.status          = status_ff;
   assign rsp.predicted_label = plabel_ff;
   assign rsp.category        = 5'(cat_ff);
   assign rsp.match_value     = m_ff;

endmodule

// ===== rtl/fuzzy_artmap_classifier.sv =====
// Fuzzy ARTMAP classifier top level: configuration registers and wiring.
// Depends on fam_pkg, fam_front, fam_back (which holds fam_div).
`timescale 1ns / 1ps

// A vector goes in one element per request (start while busy is low); the
// request with last_element set carries the mode and label and yields exactly
// one response, a single-cycle rsp_valid strobe that cannot be held off.
// busy stays high while a vector is queued or being worked on, so elements
// are taken one per cycle only between vectors. After reset the weight store
// is swept to all ones, MAX_NODES*MAX_INPUTS words (2048 by default), with
// busy high. Per vector, |I| is summed first; then each try streams the norms
// of every unflagged committed node out of the weight store and passes its
// choice ratio through a bit-serial divider; a match check uses it as well.
// Classify tries at most twice; learn repeats the search for every match
// tracking step, and learning a node streams the vector once more to update
// its weights.
// csr_ready is always high; write registers only while idle.

module fuzzy_artmap_classifier #(
   parameter int MAX_INPUTS = 64,
   parameter int MAX_NODES  = 32,
   parameter int MAX_LABELS = 16
) (
   input  logic             clock,
   input  logic             reset,
   // element requests
   input  logic             start,
   output logic             busy,
   input  fam_pkg::req_type req_data,
   // responses
   output logic             rsp_valid,
   output fam_pkg::rsp_type rsp_data,
   // register writes
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [2:0]       csr_index,
   input  logic [15:0]      csr_data
);

   localparam int IW = (MAX_INPUTS > 1) ? $clog2(MAX_INPUTS) : 1;

   fam_pkg::cfg_type cfg_ff, cfg_in;
   logic             csr_we;
   logic             back_active;
   logic             cmd_valid;
   fam_pkg::cmd_type cmd;
   logic             cmd_pop;
   logic [IW-1:0]    rd_addr;
   logic [15:0]      rd_data;

   assign csr_ready = 1'b1;
   assign csr_we    = csr_valid & csr_ready;

   // register file; indexes beyond the list are ignored
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            fam_pkg::CSR_VIGILANCE:     cfg_in.vigilance     = csr_data;
            fam_pkg::CSR_CHOICE_BIAS:   cfg_in.choice_bias   = csr_data;
            fam_pkg::CSR_TRACKING_STEP: cfg_in.tracking_step = csr_data;
            fam_pkg::CSR_VECTOR_LENGTH: cfg_in.vector_length = csr_data[6:0];
            fam_pkg::CSR_LABEL_COUNT:   cfg_in.label_count   = csr_data[4:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.vigilance     <= 16'd58982;
         cfg_ff.choice_bias   <= 16'd66;
         cfg_ff.tracking_step <= 16'd7;
         cfg_ff.vector_length <= 7'd64;
         cfg_ff.label_count   <= 5'd16;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // front: element loading and the vector queue
   fam_front #(
      .MAX_INPUTS(MAX_INPUTS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req       (req_data),
      .busy      (busy),
      .back_busy (back_active),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop),
      .rd_addr   (rd_addr),
      .rd_data   (rd_data)
   );

   // back: search, match tracking, learning
   fam_back #(
      .MAX_INPUTS(MAX_INPUTS),
      .MAX_NODES (MAX_NODES),
      .MAX_LABELS(MAX_LABELS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop),
      .active    (back_active),
      .rd_addr   (rd_addr),
      .rd_data   (rd_data),
      .rsp_valid (rsp_valid),
      .rsp       (rsp_data)
   );

endmodule
